// ===== design/bpe_pkg.sv =====
// ----------------------------------------------------------------------------
// bpe_pkg
// Shared types and constants of the bivariate polynomial evaluator: table
// size, term entry layout and stream payload layout.
// ----------------------------------------------------------------------------
package bpe_pkg;

    // Term table size and derived widths
    localparam int MAX_TERMS = 64;
    localparam int ADDR_W    = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;
    localparam int CNT_W     = $clog2(MAX_TERMS + 1);

    // Stream payload widths
    localparam int S_TDATA_W = 80;
    localparam int M_TDATA_W = 32;

    // Operation codes carried in s_tuser
    localparam logic OP_APPEND   = 1'b0;
    localparam logic OP_EVALUATE = 1'b1;

    // Status codes carried in m_tuser
    localparam logic STATUS_OK   = 1'b0;
    localparam logic STATUS_FULL = 1'b1;

    // One stored term
    typedef struct packed {
        logic [31:0] coefficient;
        logic [4:0]  x_power;
        logic [4:0]  y_power;
    } term_t;

    // Input tdata layout, last field in the lowest bits
    typedef struct packed {
        logic [5:0]  pad;
        logic [15:0] y_value;
        logic [15:0] x_value;
        logic [4:0]  y_power;
        logic [4:0]  x_power;
        logic [31:0] coefficient;
    } s_data_t;

    // Request from the sequencer to the term unit
    typedef struct packed {
        logic        start;
        term_t       term;
        logic [31:0] x_ext;
        logic [31:0] y_ext;
    } term_req_t;

    // Answer from the term unit
    typedef struct packed {
        logic        done;
        logic [31:0] product;
    } term_rsp_t;

endpackage

// ===== design/bivariate_polynomial_evaluator.sv =====
// ----------------------------------------------------------------------------
// bivariate_polynomial_evaluator
// Term table with append and evaluate items; one result item per input item.
// ----------------------------------------------------------------------------
// Works on one item at a time. An append writes the table at its acceptance
// edge; its result is loaded into the output register as the sequencer
// leaves ST_FINISH, once the output register is free, and the input is
// ready again from then on. The term is dropped with status full when the
// table already holds MAX_TERMS terms. An evaluate walks the stored terms
// one after another: each term costs a table read (ST_READ, then ST_START),
// then the term unit with its single shared 32x32 multiplier (ST_RUN). A new
// item is taken once the previous result sits in the output register, even
// if not yet drained.
module bivariate_polynomial_evaluator (
    input  logic                            aclk,
    input  logic                            aresetn,
    // Input items
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // [31:0] coefficient, [36:32] x_power, [41:37] y_power,
    // [57:42] x_value, [73:58] y_value, [79:74] zero
    input  logic [bpe_pkg::S_TDATA_W-1:0]   s_tdata,
    // [0] operation
    input  logic [0:0]                      s_tuser,
    // Result items
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // [31:0] value
    output logic [bpe_pkg::M_TDATA_W-1:0]   m_tdata,
    // [0] status
    output logic [0:0]                      m_tuser
);
    import bpe_pkg::*;

    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_READ   = 5'b00010,
        ST_START  = 5'b00100,
        ST_RUN    = 5'b01000,
        ST_FINISH = 5'b10000
    } state_t;

    state_t            state_reg, state_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [ADDR_W-1:0] idx_reg, idx_next;
    logic [31:0]       sum_reg, sum_next;
    logic              status_reg, status_next;
    logic [31:0]       x_reg, x_next;
    logic [31:0]       y_reg, y_next;
    logic              m_valid_reg, m_valid_next;
    logic [31:0]       m_data_reg, m_data_next;
    logic              m_status_reg, m_status_next;

    s_data_t   s_data;
    logic      s_accept;
    logic      is_full;
    logic      last_term;
    logic      out_free;
    logic      wr_en;
    logic      rd_en;
    term_t     wr_term;
    term_t     rd_term;
    term_req_t req;
    term_rsp_t rsp;

    assign s_data    = s_data_t'(s_tdata);
    assign s_tready  = (state_reg == ST_IDLE);
    assign s_accept  = s_tvalid && s_tready;
    assign is_full   = (count_reg == CNT_W'(MAX_TERMS));
    assign last_term = ((CNT_W'(idx_reg) + CNT_W'(1)) == count_reg);
    assign out_free  = !m_valid_reg || m_tready;

    // Table write on an accepted append with room left
    assign wr_en   = s_accept && (s_tuser[0] == OP_APPEND) && !is_full;
    assign wr_term = '{coefficient: s_data.coefficient,
                       x_power:     s_data.x_power,
                       y_power:     s_data.y_power};
    assign rd_en   = (state_reg == ST_READ);

    bpe_term_ram u_ram (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (count_reg[ADDR_W-1:0]),
        .wr_data (wr_term),
        .rd_en   (rd_en),
        .rd_addr (idx_reg),
        .rd_data (rd_term)
    );

    assign req.start = (state_reg == ST_START);
    assign req.term  = rd_term;
    assign req.x_ext = x_reg;
    assign req.y_ext = y_reg;

    bpe_term_unit u_term (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (req),
        .rsp     (rsp)
    );

    // Item sequencer
    always_comb begin
        state_next  = state_reg;
        count_next  = count_reg;
        idx_next    = idx_reg;
        sum_next    = sum_reg;
        status_next = status_reg;
        x_next      = x_reg;
        y_next      = y_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_accept) begin
                    sum_next    = 32'd0;
                    status_next = STATUS_OK;
                    idx_next    = '0;
                    x_next      = {{16{s_data.x_value[15]}}, s_data.x_value};
                    y_next      = {{16{s_data.y_value[15]}}, s_data.y_value};
                    if (s_tuser[0] == OP_APPEND) begin
                        if (is_full) begin
                            status_next = STATUS_FULL;
                        end else begin
                            count_next = count_reg + CNT_W'(1);
                        end
                        state_next = ST_FINISH;
                    end else if (count_reg == '0) begin
                        state_next = ST_FINISH;
                    end else begin
                        state_next = ST_READ;
                    end
                end
            end
            ST_READ: begin
                state_next = ST_START;
            end
            ST_START: begin
                state_next = ST_RUN;
            end
            ST_RUN: begin
                if (rsp.done) begin
                    sum_next = sum_reg + rsp.product;
                    if (last_term) begin
                        state_next = ST_FINISH;
                    end else begin
                        idx_next   = idx_reg + ADDR_W'(1);
                        state_next = ST_READ;
                    end
                end
            end
            ST_FINISH: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Output register
    always_comb begin
        m_valid_next  = m_valid_reg;
        m_data_next   = m_data_reg;
        m_status_next = m_status_reg;
        if (m_tready) begin
            m_valid_next = 1'b0;
        end
        if ((state_reg == ST_FINISH) && out_free) begin
            m_valid_next  = 1'b1;
            m_data_next   = sum_reg;
            m_status_next = status_reg;
        end
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Datapath registers
    always_ff @(posedge aclk) begin
        idx_reg      <= idx_next;
        sum_reg      <= sum_next;
        status_reg   <= status_next;
        x_reg        <= x_next;
        y_reg        <= y_next;
        m_data_reg   <= m_data_next;
        m_status_reg <= m_status_next;
    end

    assign m_tvalid   = m_valid_reg;
    assign m_tdata    = m_data_reg;
    assign m_tuser[0] = m_status_reg;

`ifndef NO_ASSERTIONS
    // Term count never passes the table size
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(MAX_TERMS))
        else $error("term count beyond table size");

    // An append with room grows the table by one
    a_append_grows: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_accept && (s_tuser[0] == OP_APPEND) && !is_full)
        |=> (count_reg == $past(count_reg) + CNT_W'(1)))
        else $error("append did not store the term");

    // An evaluate never changes the table
    a_eval_keeps: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_accept && (s_tuser[0] == OP_EVALUATE)) |=> $stable(count_reg))
        else $error("evaluate changed the term count");

    // Full status only comes with a zero value
    a_full_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && (m_status_reg == STATUS_FULL)) |-> (m_data_reg == 32'd0))
        else $error("full status with non-zero value");

    // Term unit answers only while the sequencer waits for it
    a_done_in_run: assert property (@(posedge aclk) disable iff (!aresetn)
        rsp.done |-> (state_reg == ST_RUN))
        else $error("term unit finished outside a term walk");
`endif

endmodule

// ===== design/bpe_term_ram.sv =====
// ----------------------------------------------------------------------------
// bpe_term_ram
// Term table: single write port, single read port with
// registered read data.
// ----------------------------------------------------------------------------
module bpe_term_ram (
    input  logic                        aclk,
    input  logic                        wr_en,
    input  logic [bpe_pkg::ADDR_W-1:0]  wr_addr,
    input  bpe_pkg::term_t              wr_data,
    input  logic                        rd_en,
    input  logic [bpe_pkg::ADDR_W-1:0]  rd_addr,
    output bpe_pkg::term_t              rd_data
);
    import bpe_pkg::*;

    term_t mem [MAX_TERMS];
    term_t rd_data_reg;

    // Write port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Read port, registered
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== design/bpe_term_unit.sv =====
// ----------------------------------------------------------------------------
// bpe_term_unit
// Computes coefficient * x^px * y^py modulo 2^32 by square-and-multiply on
// one shared 32x32 multiplier, one multiplication per cycle while the current power is not yet zero.
// ----------------------------------------------------------------------------
module bpe_term_unit (
    input  logic                aclk,
    input  logic                aresetn,
    input  bpe_pkg::term_req_t  req,
    output bpe_pkg::term_rsp_t  rsp
);
    import bpe_pkg::*;

    typedef enum logic [1:0] {
        U_IDLE = 2'b01,
        U_RUN  = 2'b10
    } ustate_t;

    ustate_t     state_reg, state_next;
    logic [31:0] acc_reg, acc_next;
    logic [31:0] base_reg, base_next;
    logic [4:0]  exp_reg, exp_next;
    logic [31:0] y_reg, y_next;
    logic [4:0]  yp_reg, yp_next;
    logic        phase_y_reg, phase_y_next;
    logic        mulled_reg, mulled_next;
    logic        done_reg, done_next;

    logic        do_acc;
    logic [31:0] mul_a;
    logic [31:0] mul_lo;

    // Shared multiplier: accumulate step or squaring step, low 32 bits only
    assign do_acc   = exp_reg[0] && !mulled_reg;
    assign mul_a    = do_acc ? acc_reg : base_reg;
    assign mul_lo   = mul_a * base_reg;

    // Sequencer
    always_comb begin
        state_next   = state_reg;
        acc_next     = acc_reg;
        base_next    = base_reg;
        exp_next     = exp_reg;
        y_next       = y_reg;
        yp_next      = yp_reg;
        phase_y_next = phase_y_reg;
        mulled_next  = mulled_reg;
        done_next    = 1'b0;
        unique case (state_reg)
            U_IDLE: begin
                if (req.start) begin
                    acc_next     = req.term.coefficient;
                    base_next    = req.x_ext;
                    exp_next     = req.term.x_power;
                    y_next       = req.y_ext;
                    yp_next      = req.term.y_power;
                    phase_y_next = 1'b0;
                    mulled_next  = 1'b0;
                    state_next   = U_RUN;
                end
            end
            U_RUN: begin
                priority if (exp_reg == 5'd0) begin
                    if (!phase_y_reg) begin
                        // x done, move on to y
                        base_next    = y_reg;
                        exp_next     = yp_reg;
                        phase_y_next = 1'b1;
                        mulled_next  = 1'b0;
                    end else begin
                        done_next  = 1'b1;
                        state_next = U_IDLE;
                    end
                end else if (do_acc) begin
                    acc_next    = mul_lo;
                    mulled_next = 1'b1;
                end else begin
                    base_next   = mul_lo;
                    exp_next    = exp_reg >> 1;
                    mulled_next = 1'b0;
                end
            end
            default: begin
                state_next = U_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= U_IDLE;
            done_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    // Datapath registers
    always_ff @(posedge aclk) begin
        acc_reg     <= acc_next;
        base_reg    <= base_next;
        exp_reg     <= exp_next;
        y_reg       <= y_next;
        yp_reg      <= yp_next;
        phase_y_reg <= phase_y_next;
        mulled_reg  <= mulled_next;
    end

    assign rsp.done    = done_reg;
    assign rsp.product = acc_reg;

endmodule

// ===== test/tb_bivariate_polynomial_evaluator.sv =====
// ----------------------------------------------------------------------------
// tb_bivariate_polynomial_evaluator
// Self-checking bench for the term table evaluator. Appends and evaluates
// are streamed in with random bursts and gaps while the result side stalls
// on its own pattern. Every accepted item is run through a local predictor
// of the term table, and each result item is checked in order against it.
// ----------------------------------------------------------------------------
module tb_bivariate_polynomial_evaluator;

    import bpe_pkg::*;

    localparam int ITEM_TARGET  = 580;
    localparam int IDLE_LIMIT   = 20000;
    localparam int REPORT_LIMIT = 10;

    // One expected result item
    typedef struct {
        logic [31:0] value;
        logic        status;
    } answer_t;

    // Clock, reset and block ports
    logic                 aclk     = 1'b0;
    logic                 aresetn  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    // [31:0] coefficient, [36:32] x_power, [41:37] y_power,
    // [57:42] x_value, [73:58] y_value, [79:74] zero
    logic [S_TDATA_W-1:0] s_tdata  = '0;
    // [0] operation
    logic [0:0]           s_tuser  = OP_APPEND;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    // [31:0] value
    logic [M_TDATA_W-1:0] m_tdata;
    // [0] status
    logic [0:0]           m_tuser;

    // Predictor state: a copy of the term table
    term_t       model_terms [MAX_TERMS];
    int          model_count = 0;
    answer_t     answer_q [$];
    answer_t     checked_answer;

    int          fail_count  = 0;
    int          items_sent  = 0;
    int          burst_left  = 0;
    int          idle_cycles = 0;
    logic [1:0]  stall_mode  = 2'd0;
    logic [15:0] stall_tick  = '0;

    bivariate_polynomial_evaluator i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always #5 aclk = ~aclk;

    // ------------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------------

    // base ** exponent kept to 32 bits
    function automatic logic [31:0] wrap_power(logic [31:0] base, logic [4:0] exponent);
        logic [31:0] acc;
        acc = 32'd1;
        for (int k = 0; k < exponent; k++) acc = acc * base;
        return acc;
    endfunction

    // Applies one item to the table copy and returns the result it causes
    function automatic answer_t poly_answer(logic op, s_data_t payload);
        answer_t     ans;
        logic [31:0] x_ext;
        logic [31:0] y_ext;
        ans.value  = '0;
        ans.status = STATUS_OK;
        if (op == OP_APPEND) begin
            if (model_count >= MAX_TERMS) begin
                ans.status = STATUS_FULL;
            end else begin
                model_terms[model_count].coefficient = payload.coefficient;
                model_terms[model_count].x_power     = payload.x_power;
                model_terms[model_count].y_power     = payload.y_power;
                model_count++;
            end
        end else begin
            x_ext = {{16{payload.x_value[15]}}, payload.x_value};
            y_ext = {{16{payload.y_value[15]}}, payload.y_value};
            for (int i = 0; i < model_count; i++) begin
                ans.value = ans.value + model_terms[i].coefficient
                          * wrap_power(x_ext, model_terms[i].x_power)
                          * wrap_power(y_ext, model_terms[i].y_power);
            end
        end
        return ans;
    endfunction

    // ------------------------------------------------------------------------
    // Item builders
    // ------------------------------------------------------------------------

    function automatic s_data_t make_payload(logic [31:0] coef, logic [4:0] xp,
                                             logic [4:0] yp, logic [15:0] xv,
                                             logic [15:0] yv);
        s_data_t p;
        p.pad         = '0;
        p.coefficient = coef;
        p.x_power     = xp;
        p.y_power     = yp;
        p.x_value     = xv;
        p.y_value     = yv;
        return p;
    endfunction

    // Evaluation point: wide random, small, or an extreme
    function automatic logic [15:0] pick_coord();
        logic [15:0] v;
        case ($urandom_range(0, 3))
            0, 1: v = 16'($urandom);
            2: begin
                v = 16'($urandom_range(0, 8));
                v = v - 16'd4;
            end
            default: begin
                case ($urandom_range(0, 4))
                    0: v = 16'h8000;
                    1: v = 16'h7fff;
                    2: v = 16'hffff;
                    3: v = 16'h0001;
                    default: v = 16'h0000;
                endcase
            end
        endcase
        return v;
    endfunction

    function automatic logic [4:0] pick_power();
        return $urandom_range(0, 1) ? 5'($urandom_range(0, 31)) : 5'($urandom_range(0, 3));
    endfunction

    // ------------------------------------------------------------------------
    // Sender: one item, then the gap or drain, if any, that follows it
    // ------------------------------------------------------------------------
    task automatic send_item(input logic op, input s_data_t payload,
                             input bit drain_after);
        s_tvalid <= 1'b1;
        s_tdata  <= payload;
        s_tuser  <= op;
        do @(posedge aclk); while (!s_tready);
        answer_q.push_back(poly_answer(op, payload));
        items_sent++;
        if (drain_after) begin
            s_tvalid <= 1'b0;
            while (answer_q.size() != 0) @(posedge aclk);
        end else if (burst_left == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge aclk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 60)
                                                      : $urandom_range(0, 8);
        end else begin
            burst_left--;
        end
    endtask

    task automatic send_random(input int append_pct, input bit drain_after);
        logic        op;
        logic [31:0] coef;
        op = ($urandom_range(0, 99) < append_pct) ? OP_APPEND : OP_EVALUATE;
        coef = $urandom;
        if ($urandom_range(0, 3) == 0) coef = 32'($urandom_range(0, 10)) - 32'd5;
        send_item(op, make_payload(coef, pick_power(), pick_power(), pick_coord(),
                                   pick_coord()), drain_after);
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Evaluate with nothing stored answers zero
    task automatic test_empty_table();
        send_item(OP_EVALUATE, make_payload('1, '1, '1, 16'h0000, 16'h0000), 0);
        send_item(OP_EVALUATE, make_payload('1, '1, '1, 16'h8000, 16'h7fff), 0);
        send_item(OP_EVALUATE, make_payload('0, '0, '0, 16'h7fff, 16'h8000), 0);
    endtask

    // Power zero gives one, even for a zero base
    task automatic test_zero_powers();
        send_item(OP_APPEND,   make_payload(32'd7, 5'd0, 5'd0, '1, '1), 0);
        send_item(OP_EVALUATE, make_payload('1, '1, '1, 16'h0000, 16'h0000), 0);
        send_item(OP_EVALUATE, make_payload('0, '0, '0, 16'h8000, 16'h8000), 0);
    endtask

    // Extreme coefficients, powers and points; unused fields all ones or zero
    task automatic test_field_extremes();
        send_item(OP_APPEND,   make_payload(32'h7fffffff, 5'd31, 5'd0,  '1, '0), 0);
        send_item(OP_APPEND,   make_payload(32'h80000000, 5'd0,  5'd31, '0, '1), 0);
        send_item(OP_APPEND,   make_payload(32'hffffffff, 5'd31, 5'd31, '1, '1), 0);
        send_item(OP_APPEND,   make_payload(32'h00000001, 5'd1,  5'd1,  '0, '0), 0);
        send_item(OP_APPEND,   make_payload(32'h00000000, 5'd5,  5'd5,  '1, '1), 0);
        send_item(OP_EVALUATE, make_payload('1, '1, '1, 16'd2,     16'd3), 0);
        send_item(OP_EVALUATE, make_payload('0, '0, '0, 16'hffff,  16'hffff), 0);
        send_item(OP_EVALUATE, make_payload('1, '1, '1, 16'h8000,  16'h7fff), 0);
        send_item(OP_EVALUATE, make_payload('0, '1, '0, 16'h7fff,  16'h8000), 0);
        send_item(OP_EVALUATE, make_payload('1, '0, '1, 16'h0001,  16'hffff), 0);
        send_item(OP_EVALUATE, make_payload('1, '1, '1, 16'd3,     16'hfffe), 0);
    endtask

    // Random mix while the table fills; one pause for a full drain
    task automatic test_random_growth();
        int n;
        n = 0;
        while (model_count < MAX_TERMS - 2) begin
            send_random(30, n == 60);
            n++;
        end
    endtask

    // Fill to the limit, then appends are dropped and the sum is unchanged
    task automatic test_table_full();
        while (model_count < MAX_TERMS) send_random(100, 0);
        send_item(OP_EVALUATE, make_payload('0, '0, '0, 16'd1, 16'd1), 0);
        send_item(OP_APPEND,   make_payload(32'h80000000, 5'd31, 5'd31, '1, '1), 0);
        send_item(OP_APPEND,   make_payload(32'h7fffffff, 5'd0,  5'd0,  '0, '0), 0);
        send_item(OP_EVALUATE, make_payload('1, '1, '1, 16'd1, 16'd1), 0);
        send_item(OP_EVALUATE, make_payload('1, '1, '1, 16'hffff, 16'd1), 0);
    endtask

    // Random mix on the full table; the last item drains the pipe
    task automatic test_random_full();
        while (items_sent < ITEM_TARGET - 1) send_random(50, 0);
        send_random(50, 1);
    endtask

    // ------------------------------------------------------------------------
    // Result side: stall pattern and in-order checking
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin
        stall_tick <= stall_tick + 16'd1;
        if (stall_tick[5:0] == 6'd0) stall_mode <= 2'($urandom_range(0, 3));
        case (stall_mode)
            2'd0:    m_tready <= 1'b1;
            2'd1:    m_tready <= ($urandom_range(0, 3) != 0);
            2'd2:    m_tready <= (stall_tick[2:0] == 3'd0);
            default: m_tready <= 1'($urandom_range(0, 1));
        endcase
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (answer_q.size() == 0) begin
                fail_count++;
                if (fail_count <= REPORT_LIMIT)
                    $display("unexpected result item: value %h status %0d",
                             m_tdata, m_tuser);
            end else begin
                checked_answer = answer_q.pop_front();
                if (m_tdata !== checked_answer.value || m_tuser !== checked_answer.status) begin
                    fail_count++;
                    if (fail_count <= REPORT_LIMIT)
                        $display("mismatch: value exp %h got %h, status exp %0d got %0d",
                                 checked_answer.value, m_tdata, checked_answer.status,
                                 m_tuser);
                end
            end
        end
    end

    // Watchdog: cycles without any accepted item on either side
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------------
    initial begin
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_empty_table();
        test_zero_powers();
        test_field_extremes();
        test_random_growth();
        test_table_full();
        test_random_full();
        repeat (40) @(posedge aclk);
        if (fail_count == 0 && answer_q.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
